// ===== sv/psev_pkg.sv =====
`timescale 1ns / 1ps
package psev_pkg;

  localparam int unsigned IN_W   = 16;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned PROD_W = 32;
  localparam int unsigned DOT_W  = 33;
  localparam int unsigned FRAC_IN = 14;
  localparam int unsigned A_W    = DOT_W - FRAC_IN;
  localparam int unsigned AB_W   = A_W + DOT_W;
  localparam int unsigned D_W    = AB_W + 1;
  localparam int unsigned DM_W   = D_W - 1;
  localparam int unsigned P_W    = 6;
  localparam int unsigned D_FRAC = 42;
  localparam int unsigned L_W    = 23;
  localparam int unsigned Y_W    = L_W + CFG_W + 1;
  localparam int unsigned K_W    = Y_W - 24;
  localparam int unsigned E_W    = 31;
  localparam int unsigned CK_W   = 2 * CFG_W;
  localparam int unsigned VAL_W  = CK_W + E_W;
  localparam int unsigned OUT_SHIFT = 46;

  // register indexes
  localparam logic [IDX_W-1:0] REG_COLOR_RED   = 3'd0;
  localparam logic [IDX_W-1:0] REG_COLOR_GREEN = 3'd1;
  localparam logic [IDX_W-1:0] REG_COLOR_BLUE  = 3'd2;
  localparam logic [IDX_W-1:0] REG_SPEC_GAIN   = 3'd3;
  localparam logic [IDX_W-1:0] REG_SHININESS   = 3'd4;

  localparam logic [CFG_W-1:0] COLOR_RST     = 16'd16384;
  localparam logic [CFG_W-1:0] SHININESS_RST = 16'd2560;

  function automatic logic [63:0] isqrt_f(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] rem;
    res = '0;
    bitv = 64'd1 << 62;
    rem = v;
    for (int i = 0; i < 32; i++) begin
      if (bitv > rem) bitv = bitv >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bitv != 64'd0) begin
        if (rem >= res + bitv) begin
          rem = rem - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

  // log2(1.f) in Q16 by repeated squaring
  function automatic logic [15:0] log_frac_f(input int unsigned frac, input int unsigned tb);
    logic [63:0] x;
    logic [15:0] res;
    x = (64'(frac) + (64'd1 << tb)) << (30 - tb);
    res = '0;
    for (int k = 1; k <= 16; k++) begin
      x = (x * x) >> 30;
      if (x >= (64'd2 << 30)) begin
        x = x >> 1;
        res[16-k] = 1'b1;
      end
    end
    return res;
  endfunction

  // 2^(g / 2^tb) in Q30
  function automatic logic [E_W-1:0] exp_frac_f(input int unsigned g, input int unsigned tb);
    logic [63:0] e;
    logic [63:0] c;
    e = 64'd1 << 30;
    c = isqrt_f(64'd1 << 61);
    for (int k = 1; k <= tb; k++) begin
      if (((g >> (tb - k)) & 1) != 0) e = (e * c) >> 30;
      c = isqrt_f(c << 30);
    end
    return E_W'(e);
  endfunction

endpackage

// ===== sv/psev_if.sv =====
`timescale 1ns / 1ps
interface psev_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic signed [15:0] in_dir_x;
  logic signed [15:0] in_dir_y;
  logic signed [15:0] in_dir_z;
  logic signed [15:0] out_dir_x;
  logic signed [15:0] out_dir_y;
  logic signed [15:0] out_dir_z;
  modport source(output valid, normal_x, normal_y, normal_z, in_dir_x, in_dir_y, in_dir_z,
                 out_dir_x, out_dir_y, out_dir_z, input ready);
  modport sink(input valid, normal_x, normal_y, normal_z, in_dir_x, in_dir_y, in_dir_z,
               out_dir_x, out_dir_y, out_dir_z, output ready);
endinterface

interface psev_out_if;
  logic valid;
  logic ready;
  logic [15:0] spec_red;
  logic [15:0] spec_green;
  logic [15:0] spec_blue;
  modport source(output valid, spec_red, spec_green, spec_blue, input ready);
  modport sink(input valid, spec_red, spec_green, spec_blue, output ready);
endinterface

// ===== sv/psev_dot.sv =====
`timescale 1ns / 1ps
module psev_dot (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic signed [psev_pkg::IN_W-1:0] n [3],
  input  logic signed [psev_pkg::IN_W-1:0] wi [3],
  input  logic signed [psev_pkg::IN_W-1:0] wo [3],
  output logic d_valid,
  output logic signed [psev_pkg::D_W-1:0] d
);
  import psev_pkg::*;

  logic signed [PROD_W-1:0] p_nwi [3];
  logic signed [PROD_W-1:0] p_nwo [3];
  logic signed [PROD_W-1:0] p_wiwo [3];
  logic v1, v2, v3;
  logic signed [DOT_W-1:0] sum_a, sum_b, sum_c;
  logic signed [A_W-1:0] a2;
  logic signed [DOT_W-1:0] b2, c2, c3;
  logic signed [AB_W-1:0] ab3;

  always_comb begin
    sum_a = DOT_W'(p_nwi[0]) + DOT_W'(p_nwi[1]) + DOT_W'(p_nwi[2]);
    sum_b = DOT_W'(p_nwo[0]) + DOT_W'(p_nwo[1]) + DOT_W'(p_nwo[2]);
    sum_c = DOT_W'(p_wiwo[0]) + DOT_W'(p_wiwo[1]) + DOT_W'(p_wiwo[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      d_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      d_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p_nwi[i]  <= n[i] * wi[i];
        p_nwo[i]  <= n[i] * wo[i];
        p_wiwo[i] <= wi[i] * wo[i];
      end
      // floor of n.wi to q14
      a2  <= sum_a[DOT_W-1:FRAC_IN];
      b2  <= sum_b;
      c2  <= sum_c;
      ab3 <= a2 * b2;
      c3  <= c2;
      d   <= (D_W'(ab3) <<< 1) - (D_W'(c3) <<< FRAC_IN);
    end
  end
endmodule

// ===== sv/psev_log.sv =====
`timescale 1ns / 1ps
module psev_log #(
  parameter int unsigned LOG_TABLE_BITS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic d_valid,
  input  logic signed [psev_pkg::D_W-1:0] d,
  input  logic [psev_pkg::CFG_W-1:0] shininess,
  output logic y_valid,
  output logic y_pos,
  output logic signed [psev_pkg::Y_W-1:0] y
);
  import psev_pkg::*;

  localparam int unsigned TabN = 2 ** LOG_TABLE_BITS;

  logic [15:0] log_tab [TabN];
  logic v1, v2, v3;
  logic pos1, pos2, pos3;
  logic [DM_W-1:0] dm1;
  logic [P_W-1:0] lead, p1, p2;
  logic [DM_W-1:0] norm;
  logic [LOG_TABLE_BITS-1:0] f2;
  logic signed [P_W:0] pe;
  logic signed [L_W-1:0] l3;

  for (genvar gi = 0; gi < TabN; gi++) begin : g_log_tab
    assign log_tab[gi] = log_frac_f(gi, LOG_TABLE_BITS);
  end

  always_comb begin
    lead = '0;
    for (int i = 0; i < DM_W; i++) begin
      if (d[i]) lead = P_W'(i);
    end
    norm = dm1 << (P_W'(DM_W - 1) - p1);
    pe = signed'({1'b0, p2}) - (P_W+1)'(D_FRAC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      y_valid <= 1'b0;
    end else if (en) begin
      v1 <= d_valid;
      v2 <= v1;
      v3 <= v2;
      y_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos1 <= (d > 0);
      dm1  <= d[DM_W-1:0];
      p1   <= lead;
      pos2 <= pos1;
      p2   <= p1;
      f2   <= norm[DM_W-2 -: LOG_TABLE_BITS];
      pos3 <= pos2;
      l3   <= {pe, log_tab[f2]};
      y_pos <= pos3;
      y    <= signed'({1'b0, shininess}) * l3;
    end
  end
endmodule

// ===== sv/psev_exp.sv =====
`timescale 1ns / 1ps
module psev_exp #(
  parameter int unsigned LOG_TABLE_BITS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic y_valid,
  input  logic y_pos,
  input  logic signed [psev_pkg::Y_W-1:0] y,
  input  logic [psev_pkg::CFG_W-1:0] color [3],
  input  logic [psev_pkg::CFG_W-1:0] spec_gain,
  output logic o_valid,
  output logic [15:0] spec [3]
);
  import psev_pkg::*;

  localparam int unsigned TabN = 2 ** LOG_TABLE_BITS;

  logic [E_W-1:0] exp_tab [TabN];
  logic v1, v2, pos1, pos2;
  logic signed [K_W-1:0] k1, k2;
  logic [E_W-1:0] e1;
  logic [CK_W-1:0] ck1 [3];
  logic [VAL_W-1:0] val2 [3];
  logic signed [K_W:0] s;
  logic [VAL_W-1:0] r [3];
  logic [15:0] res [3];

  for (genvar gi = 0; gi < TabN; gi++) begin : g_exp_tab
    assign exp_tab[gi] = exp_frac_f(gi, LOG_TABLE_BITS);
  end

  always_comb begin
    s = (K_W+1)'(OUT_SHIFT) - (K_W+1)'(k2);
    for (int c = 0; c < 3; c++) begin
      r[c] = val2[c] >> s[5:0];
      if (!pos2 || val2[c] == '0 || s >= (K_W+1)'(64)) res[c] = '0;
      else if (s <= 0 || r[c][VAL_W-1:16] != '0) res[c] = 16'hFFFF;
      else res[c] = r[c][15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      o_valid <= 1'b0;
    end else if (en) begin
      v1 <= y_valid;
      v2 <= v1;
      o_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos1 <= y_pos;
      k1   <= y[Y_W-1:24];
      e1   <= exp_tab[y[23 -: LOG_TABLE_BITS]];
      pos2 <= pos1;
      k2   <= k1;
      for (int c = 0; c < 3; c++) begin
        ck1[c]  <= color[c] * spec_gain;
        val2[c] <= ck1[c] * e1;
        spec[c] <= res[c];
      end
    end
  end
endmodule

// ===== sv/phong_specular_eval_unit.sv =====
`timescale 1ns / 1ps
// phong glossy specular evaluation, fully pipelined
// pipeline: 11 register stages (4 dot, 4 log, 3 exp/scale)
// throughput: one word per cycle; the whole pipe advances when the output is free or taken
// reset (rst, synchronous, active high) clears all valid bits and loads
// color and gain to 1.0 and shininess to 10.0
module phong_specular_eval_unit #(
  parameter int unsigned LOG_TABLE_BITS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [psev_pkg::IDX_W-1:0] cfg_index,
  input  logic [psev_pkg::CFG_W-1:0] cfg_data,
  psev_in_if.sink    sample_in,
  psev_out_if.source result_out
);
  import psev_pkg::*;

  // configuration registers
  logic [CFG_W-1:0] color [3];
  logic [CFG_W-1:0] spec_gain;
  logic [CFG_W-1:0] shininess;

  // one global advance: every stage moves together unless the output word is stuck
  logic en;

  logic signed [IN_W-1:0] n [3];
  logic signed [IN_W-1:0] wi [3];
  logic signed [IN_W-1:0] wo [3];

  logic d_valid;
  logic signed [D_W-1:0] d;
  logic y_valid, y_pos;
  logic signed [Y_W-1:0] y;
  logic [15:0] spec [3];

  assign en = !result_out.valid || result_out.ready;
  assign sample_in.ready = en;

  assign n  = '{sample_in.normal_x, sample_in.normal_y, sample_in.normal_z};
  assign wi = '{sample_in.in_dir_x, sample_in.in_dir_y, sample_in.in_dir_z};
  assign wo = '{sample_in.out_dir_x, sample_in.out_dir_y, sample_in.out_dir_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      color[0]  <= COLOR_RST;
      color[1]  <= COLOR_RST;
      color[2]  <= COLOR_RST;
      spec_gain <= COLOR_RST;
      shininess <= SHININESS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLOR_RED:   color[0]  <= cfg_data;
        REG_COLOR_GREEN: color[1]  <= cfg_data;
        REG_COLOR_BLUE:  color[2]  <= cfg_data;
        REG_SPEC_GAIN:   spec_gain <= cfg_data;
        REG_SHININESS:   shininess <= cfg_data;
        default: ;
      endcase
    end
  end

  // dot products, reflection and d = r.wo in q42
  psev_dot u_dot (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(sample_in.valid && en),
    .n(n), .wi(wi), .wo(wo),
    .d_valid(d_valid), .d(d)
  );

  // leading one, log2 table, times shininess
  psev_log #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_log (
    .clk(clk), .rst(rst), .en(en),
    .d_valid(d_valid), .d(d), .shininess(shininess),
    .y_valid(y_valid), .y_pos(y_pos), .y(y)
  );

  // exp2 table, color * ks scale, shift and saturate; last stage is the output register
  psev_exp #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_exp (
    .clk(clk), .rst(rst), .en(en),
    .y_valid(y_valid), .y_pos(y_pos), .y(y),
    .color(color), .spec_gain(spec_gain),
    .o_valid(result_out.valid), .spec(spec)
  );

  assign result_out.spec_red   = spec[0];
  assign result_out.spec_green = spec[1];
  assign result_out.spec_blue  = spec[2];
endmodule

// ===== sv/psev_check.sv =====
`timescale 1ns / 1ps
module psev_check (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [15:0] spec_red
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped under stall");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(spec_red))
    else $error("output word changed under stall");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output side");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_nostall_in: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");
endmodule

bind phong_specular_eval_unit psev_check u_psev_check (
  .clk(clk), .rst(rst),
  .in_ready(sample_in.ready),
  .out_valid(result_out.valid), .out_ready(result_out.ready),
  .spec_red(result_out.spec_red)
);
